[rtl/rvm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rvm_pkg;

    localparam int RES_W     = 24;
    localparam int SQ_W      = 48;
    localparam int BSUM_W    = 60;
    localparam int FILL_W    = 13;
    localparam int DEN_W     = 37;
    localparam int DIV_W     = 68;
    localparam int ROOT_W    = 54;
    localparam int SOP_W     = 108;
    localparam int SREM_W    = 58;
    localparam int RMS_W     = 27;
    localparam int RSQ_W     = 54;
    localparam int S1_W      = 37;
    localparam int S2_W      = 64;
    localparam int TALLY_W   = 11;
    localparam int A_W       = 75;
    localparam int B_W       = 74;
    localparam int VAR_W     = 32;
    localparam int CNT_W     = 7;

    localparam int DIV_STEPS  = 68;
    localparam int SQRT_STEPS = 54;

    localparam logic [FILL_W-1:0] SIZE_RESET = FILL_W'(64);
    localparam logic [FILL_W-1:0] SIZE_MAX   = FILL_W'(4096);
    localparam logic [RMS_W-1:0]  RMS_MAX    = '1;

    localparam logic [1:0] SEL_A = 2'd0;
    localparam logic [1:0] SEL_B = 2'd1;
    localparam logic [1:0] SEL_C = 2'd2;

    localparam logic SRC_BLOCK = 1'b0;
    localparam logic SRC_STAT  = 1'b1;

    typedef struct packed {
        logic       cap;
        logic       sq_en;
        logic [1:0] sq_sel;
        logic       acc_en;
        logic       fill_inc;
        logic       div_ld;
        logic       div_src;
        logic       div_step;
        logic       sqrt_ld;
        logic       sqrt_src;
        logic       sqrt_step;
        logic       rms_ld;
        logic       rsq_ld;
        logic       stat_acc;
        logic       vmul_lo;
        logic       vmul_hi;
        logic       var_zero;
        logic       var_quot;
        logic       res_ld;
    } t_cmd;

    typedef struct packed {
        logic fill_ge;
        logic fill_nz;
        logic final_item;
        logic s1_zero;
        logic b_gt_a;
        logic out_busy;
    } t_sts;

endpackage

`default_nettype wire

[rtl/rvm_ifs.sv]
`timescale 1ns / 1ps
`default_nettype none

interface rvm_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [rvm_pkg::RES_W-1:0]  residual_a;
    logic signed [rvm_pkg::RES_W-1:0]  residual_b;
    logic signed [rvm_pkg::RES_W-1:0]  residual_c;
    logic                              final_sample;
    modport source (output valid, residual_a, residual_b, residual_c, final_sample,
                    input ready);
    modport sink (input valid, residual_a, residual_b, residual_c, final_sample,
                  output ready);
endinterface

interface rvm_out_if;
    logic                              valid;
    logic                              ready;
    logic [rvm_pkg::VAR_W-1:0]         variation;
    logic [rvm_pkg::TALLY_W-1:0]       blocks_seen;
    logic                              overflowed;
    modport source (output valid, variation, blocks_seen, overflowed, input ready);
    modport sink (input valid, variation, blocks_seen, overflowed, output ready);
endinterface

interface rvm_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [rvm_pkg::FILL_W-1:0]        data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

[rtl/rvm_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module rvm_datapath #(
    parameter int MAX_BLOCKS    = 1024,
    parameter int RESIDUAL_BITS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rvm_pkg::t_cmd                       i_cmd,
    output rvm_pkg::t_sts                       o_sts,
    input  logic signed [rvm_pkg::RES_W-1:0]    i_res_a,
    input  logic signed [rvm_pkg::RES_W-1:0]    i_res_b,
    input  logic signed [rvm_pkg::RES_W-1:0]    i_res_c,
    input  logic                                i_final,
    input  logic                                i_cfg_we,
    input  logic [rvm_pkg::FILL_W-1:0]          i_cfg_data,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [rvm_pkg::VAR_W-1:0]           o_variation,
    output logic [rvm_pkg::TALLY_W-1:0]         o_blocks_seen,
    output logic                                o_overflowed
);
    import rvm_pkg::*;

    localparam logic signed [RES_W:0] LIM_HI = (RES_W+1)'((1 <<< (RESIDUAL_BITS-1)) - 1);
    localparam logic signed [RES_W:0] LIM_LO = (RES_W+1)'(-(1 <<< (RESIDUAL_BITS-1)));
    localparam logic [TALLY_W-1:0]    TALLY_LIM = TALLY_W'(MAX_BLOCKS);

    function automatic logic [RES_W-1:0] mag(input logic signed [RES_W-1:0] x);
        logic signed [RES_W:0] v;
        v = {x[RES_W-1], x};
        if (v > LIM_HI) begin
            v = LIM_HI;
        end else if (v < LIM_LO) begin
            v = LIM_LO;
        end
        if (v < 0) begin
            v = -v;
        end
        return v[RES_W-1:0];
    endfunction

    logic [FILL_W-1:0]  r_size;
    logic [RES_W-1:0]   r_ua, r_ub, r_uc;
    logic               r_final;
    logic [SQ_W-1:0]    r_prod;
    logic [BSUM_W-1:0]  r_bsum;
    logic [FILL_W-1:0]  r_fill;
    logic [DIV_W-1:0]   r_dq;
    logic [DEN_W-1:0]   r_dr;
    logic [DEN_W-1:0]   r_dd;
    logic [SOP_W-1:0]   r_sop;
    logic [SREM_W-1:0]  r_srem;
    logic [ROOT_W-1:0]  r_sroot;
    logic [RMS_W-1:0]   r_rms;
    logic [RSQ_W-1:0]   r_rms2;
    logic [S1_W-1:0]    r_s1;
    logic [S2_W-1:0]    r_s2;
    logic [TALLY_W-1:0] r_tally;
    logic               r_ovf;
    logic [A_W-1:0]     r_a;
    logic [B_W-1:0]     r_b;
    logic [VAR_W-1:0]   r_var;
    logic               r_out_valid;
    logic [VAR_W-1:0]   r_out_var;
    logic [TALLY_W-1:0] r_out_tally;
    logic               r_out_ovf;

    logic [FILL_W-1:0]  eff_size;
    logic [RES_W-1:0]   sq_op;
    logic [DEN_W-1:0]   den_blk;
    logic [DEN_W:0]     div_t;
    logic [DEN_W:0]     div_d;
    logic [SREM_W-1:0]  sq_t;
    logic [SREM_W-1:0]  sq_trial;
    logic [A_W-1:0]     diff;

    always_comb begin
        if (r_size == '0) begin
            eff_size = FILL_W'(1);
        end else if (r_size > SIZE_MAX) begin
            eff_size = SIZE_MAX;
        end else begin
            eff_size = r_size;
        end
        case (i_cmd.sq_sel)
            SEL_A:   sq_op = r_ua;
            SEL_B:   sq_op = r_ub;
            SEL_C:   sq_op = r_uc;
            default: sq_op = r_uc;
        endcase
        den_blk  = DEN_W'({r_fill, 1'b0}) + DEN_W'(r_fill);
        div_t    = {r_dr, r_dq[DIV_W-1]};
        div_d    = {1'b0, r_dd};
        sq_t     = {r_srem[SREM_W-3:0], r_sop[SOP_W-1:SOP_W-2]};
        sq_trial = SREM_W'({r_sroot, 2'b01});
        diff     = r_a - A_W'(r_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size      <= SIZE_RESET;
            r_final     <= 1'b0;
            r_bsum      <= '0;
            r_fill      <= '0;
            r_s1        <= '0;
            r_s2        <= '0;
            r_tally     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_size <= i_cfg_data;
            end
            if (i_cmd.cap) begin
                r_final <= i_final;
            end
            if (i_cmd.acc_en) begin
                r_bsum <= r_bsum + BSUM_W'(r_prod);
            end
            if (i_cmd.fill_inc) begin
                r_fill <= r_fill + FILL_W'(1);
            end
            if (i_cmd.stat_acc) begin
                if (r_tally < TALLY_LIM) begin
                    r_s1    <= r_s1 + S1_W'(r_rms);
                    r_s2    <= r_s2 + S2_W'(r_rms2);
                    r_tally <= r_tally + TALLY_W'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
                r_bsum <= '0;
                r_fill <= '0;
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.res_ld) begin
                r_out_valid <= 1'b1;
                r_s1        <= '0;
                r_s2        <= '0;
                r_tally     <= '0;
                r_ovf       <= 1'b0;
                r_bsum      <= '0;
                r_fill      <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_ua <= mag(i_res_a);
            r_ub <= mag(i_res_b);
            r_uc <= mag(i_res_c);
        end
        if (i_cmd.sq_en) begin
            r_prod <= sq_op * sq_op;
        end
        if (i_cmd.div_ld) begin
            r_dr <= '0;
            if (i_cmd.div_src == SRC_BLOCK) begin
                r_dq <= {r_bsum, 8'b0};
                r_dd <= den_blk;
            end else begin
                r_dq <= DIV_W'(r_sroot);
                r_dd <= r_s1;
            end
        end else if (i_cmd.div_step) begin
            if (div_t >= div_d) begin
                r_dr <= DEN_W'(div_t - div_d);
                r_dq <= {r_dq[DIV_W-2:0], 1'b1};
            end else begin
                r_dr <= div_t[DEN_W-1:0];
                r_dq <= {r_dq[DIV_W-2:0], 1'b0};
            end
        end
        if (i_cmd.sqrt_ld) begin
            r_srem  <= '0;
            r_sroot <= '0;
            if (i_cmd.sqrt_src == SRC_BLOCK) begin
                r_sop <= SOP_W'(r_dq);
            end else begin
                r_sop <= SOP_W'({diff, 32'b0});
            end
        end else if (i_cmd.sqrt_step) begin
            r_sop <= {r_sop[SOP_W-3:0], 2'b00};
            if (sq_t >= sq_trial) begin
                r_srem  <= sq_t - sq_trial;
                r_sroot <= {r_sroot[ROOT_W-2:0], 1'b1};
            end else begin
                r_srem  <= sq_t;
                r_sroot <= {r_sroot[ROOT_W-2:0], 1'b0};
            end
        end
        if (i_cmd.rms_ld) begin
            r_rms <= (r_sroot > ROOT_W'(RMS_MAX)) ? RMS_MAX : r_sroot[RMS_W-1:0];
        end
        if (i_cmd.rsq_ld) begin
            r_rms2 <= r_rms * r_rms;
        end
        if (i_cmd.vmul_lo) begin
            r_a <= A_W'(r_tally * r_s2);
            r_b <= B_W'(r_s1 * r_s1[31:0]);
        end
        if (i_cmd.vmul_hi) begin
            r_b <= r_b + (B_W'(r_s1 * r_s1[S1_W-1:32]) << 32);
        end
        if (i_cmd.var_zero) begin
            r_var <= '0;
        end
        if (i_cmd.var_quot) begin
            r_var <= (|r_dq[DIV_W-1:VAR_W]) ? '1 : r_dq[VAR_W-1:0];
        end
        if (i_cmd.res_ld) begin
            r_out_var   <= r_var;
            r_out_tally <= r_tally;
            r_out_ovf   <= r_ovf;
        end
    end

    assign o_sts.fill_ge    = (r_fill >= eff_size);
    assign o_sts.fill_nz    = (r_fill != '0);
    assign o_sts.final_item = r_final;
    assign o_sts.s1_zero    = (r_s1 == '0);
    assign o_sts.b_gt_a     = ({1'b0, r_b} > r_a);
    assign o_sts.out_busy   = r_out_valid;

    assign o_out_valid   = r_out_valid;
    assign o_variation   = r_out_var;
    assign o_blocks_seen = r_out_tally;
    assign o_overflowed  = r_out_ovf;

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= SIZE_MAX)
        else $error("block fill beyond largest block");
    a_tally_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tally <= TALLY_LIM)
        else $error("block tally beyond limit");
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_cmd.res_ld))
        else $error("result raised without load");
`endif

endmodule

`default_nettype wire

[rtl/rvm_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module rvm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  rvm_pkg::t_sts  i_sts,
    output rvm_pkg::t_cmd  o_cmd
);
    import rvm_pkg::*;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_MUL0 = 5'd1;
    localparam logic [4:0] S_MUL1 = 5'd2;
    localparam logic [4:0] S_MUL2 = 5'd3;
    localparam logic [4:0] S_ADD  = 5'd4;
    localparam logic [4:0] S_CHK  = 5'd5;
    localparam logic [4:0] S_BDIV = 5'd6;
    localparam logic [4:0] S_BSQL = 5'd7;
    localparam logic [4:0] S_BSQ  = 5'd8;
    localparam logic [4:0] S_RMS  = 5'd9;
    localparam logic [4:0] S_RSQ  = 5'd10;
    localparam logic [4:0] S_ACC  = 5'd11;
    localparam logic [4:0] S_FIN  = 5'd12;
    localparam logic [4:0] S_VHI  = 5'd13;
    localparam logic [4:0] S_VCHK = 5'd14;
    localparam logic [4:0] S_VSQ  = 5'd15;
    localparam logic [4:0] S_VDL  = 5'd16;
    localparam logic [4:0] S_VDIV = 5'd17;
    localparam logic [4:0] S_VSAT = 5'd18;
    localparam logic [4:0] S_OUTW = 5'd19;

    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIV_STEPS - 1);
    localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(SQRT_STEPS - 1);

    logic [4:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt + CNT_W'(1);
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_MUL0;
                end
            end
            S_MUL0: begin
                o_cmd.sq_en  = 1'b1;
                o_cmd.sq_sel = SEL_A;
                n_state      = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.sq_en  = 1'b1;
                o_cmd.sq_sel = SEL_B;
                o_cmd.acc_en = 1'b1;
                n_state      = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.sq_en  = 1'b1;
                o_cmd.sq_sel = SEL_C;
                o_cmd.acc_en = 1'b1;
                n_state      = S_ADD;
            end
            S_ADD: begin
                o_cmd.acc_en   = 1'b1;
                o_cmd.fill_inc = 1'b1;
                n_state        = S_CHK;
            end
            S_CHK: begin
                if (i_sts.fill_ge || (i_sts.final_item && i_sts.fill_nz)) begin
                    o_cmd.div_ld  = 1'b1;
                    o_cmd.div_src = SRC_BLOCK;
                    n_cnt         = '0;
                    n_state       = S_BDIV;
                end else if (i_sts.final_item) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_BDIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_BSQL;
                end
            end
            S_BSQL: begin
                o_cmd.sqrt_ld  = 1'b1;
                o_cmd.sqrt_src = SRC_BLOCK;
                n_cnt          = '0;
                n_state        = S_BSQ;
            end
            S_BSQ: begin
                o_cmd.sqrt_step = 1'b1;
                if (r_cnt == SQRT_LAST) begin
                    n_state = S_RMS;
                end
            end
            S_RMS: begin
                o_cmd.rms_ld = 1'b1;
                n_state      = S_RSQ;
            end
            S_RSQ: begin
                o_cmd.rsq_ld = 1'b1;
                n_state      = S_ACC;
            end
            S_ACC: begin
                o_cmd.stat_acc = 1'b1;
                n_state        = i_sts.final_item ? S_FIN : S_IDLE;
            end
            S_FIN: begin
                if (i_sts.s1_zero) begin
                    o_cmd.var_zero = 1'b1;
                    n_state        = S_OUTW;
                end else begin
                    o_cmd.vmul_lo = 1'b1;
                    n_state       = S_VHI;
                end
            end
            S_VHI: begin
                o_cmd.vmul_hi = 1'b1;
                n_state       = S_VCHK;
            end
            S_VCHK: begin
                if (i_sts.b_gt_a) begin
                    o_cmd.var_zero = 1'b1;
                    n_state        = S_OUTW;
                end else begin
                    o_cmd.sqrt_ld  = 1'b1;
                    o_cmd.sqrt_src = SRC_STAT;
                    n_cnt          = '0;
                    n_state        = S_VSQ;
                end
            end
            S_VSQ: begin
                o_cmd.sqrt_step = 1'b1;
                if (r_cnt == SQRT_LAST) begin
                    n_state = S_VDL;
                end
            end
            S_VDL: begin
                o_cmd.div_ld  = 1'b1;
                o_cmd.div_src = SRC_STAT;
                n_cnt         = '0;
                n_state       = S_VDIV;
            end
            S_VDIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_VSAT;
                end
            end
            S_VSAT: begin
                o_cmd.var_quot = 1'b1;
                n_state        = S_OUTW;
            end
            S_OUTW: begin
                if (!i_sts.out_busy) begin
                    o_cmd.res_ld = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

`default_nettype wire

[rtl/block_rms_variation_meter.sv]
`timescale 1ns / 1ps
`default_nettype none

// Takes one residual triple per request and returns one result on the request marked
// final_sample. A request that closes no block occupies the block while one shared
// 24x24 squarer is used three times. A request that closes a block also runs a 68-step
// bit-serial divider, which forms 256*sum/(3*count), and a 54-step digit-serial root,
// which forms the block RMS. A final request also passes through the same root and
// divider units for the coefficient of variation (skipped when the mean is zero) and any
// wait for an earlier result to leave the output register; the result then waits in
// that register while new requests are taken. Configuration is always ready.
module block_rms_variation_meter #(
    parameter int MAX_BLOCKS    = 1024,
    parameter int RESIDUAL_BITS = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rvm_in_if.sink        i_samp,
    rvm_out_if.source     o_res,
    rvm_cfg_if.sink       i_cfg
);
    import rvm_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic ctl_ready;

    assign i_samp.ready = ctl_ready;
    assign i_cfg.ready  = 1'b1;

    rvm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_samp.valid),
        .o_in_ready (ctl_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rvm_datapath #(
        .MAX_BLOCKS    (MAX_BLOCKS),
        .RESIDUAL_BITS (RESIDUAL_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_res_a       (i_samp.residual_a),
        .i_res_b       (i_samp.residual_b),
        .i_res_c       (i_samp.residual_c),
        .i_final       (i_samp.final_sample),
        .i_cfg_we      (i_cfg.valid),
        .i_cfg_data    (i_cfg.data),
        .i_out_ready   (o_res.ready),
        .o_out_valid   (o_res.valid),
        .o_variation   (o_res.variation),
        .o_blocks_seen (o_res.blocks_seen),
        .o_overflowed  (o_res.overflowed)
    );

endmodule

`default_nettype wire
